/* design/brs_pkg.sv */
`default_nettype none
package brs_pkg;

    // block geometry; block size is a power of two
    localparam int BLOCK_BYTES = 1024;
    localparam int BLOCK_SHIFT = 10;

    localparam int FL_W    = 42;                        // file length / byte offset
    localparam int BLK_W   = 32;                        // block id
    localparam int RB_W    = 16;                        // range length, index in range
    localparam int PASS_W  = 8;
    localparam int LEN_W   = 11;
    localparam int TOTAL_W = FL_W - BLOCK_SHIFT + 1;    // block count of the file

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 42;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BLOCKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_PASSES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH  = 3'd4;

    localparam logic [RB_W-1:0] RANGE_BLOCKS_RST = 16'd128;

    typedef enum logic [1:0] {
        PH_SENDING,
        PH_END,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [RB_W-1:0]    range_blocks;
        logic [PASS_W-1:0]  extra_passes;
        logic [BLK_W-1:0]   block_limit;
        logic [BLK_W-1:0]   first_block;
        logic [FL_W-1:0]    file_length;
        logic [TOTAL_W-1:0] total_blocks;   // ceil(file_length / BLOCK_BYTES)
    } t_cfg;

endpackage
`default_nettype wire

/* design/block_retransmit_scheduler_core.sv */
`default_nettype none
// Packet descriptor generator for a file sender that repeats each range of
// blocks extra_passes+1 times, then sends a header-only end marker.
// Request channel (s side): one beat per descriptor wanted; tdata[0] = restart
// (1 starts the schedule over at first_block). Each request gives exactly one
// descriptor beat on the m side: tdata holds block_number, byte_offset,
// payload_len and pass_number; tuser flags the end marker or "finished".
// Config channel: index/data writes, always ready; write only while idle.
// A new file_length and its block count both take effect at the write edge.
// A request's descriptor is written into the output register at the edge that
// accepts the request.
// Throughput: one descriptor per cycle unless stalled; the schedule counters and
// output register update in the same cycle: back-to-back requests run at full rate.
// Stall: the output register holds its beat while i_m_tready is low; a new
// request is taken only when that register is empty or being drained.
// Reset (synchronous, active low): config registers go to their defaults
// (range 128 blocks, no repeats, no limit, start block 0, empty file),
// schedule counters clear, the output register empties.
module block_retransmit_scheduler_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request: [0] restart
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [brs_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // descriptor: [31:0] block_number, [73:32] byte_offset,
    // [84:74] payload_len, [92:85] pass_number, [95:93] zero
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [brs_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // [0] end_marker, [1] finished
    output logic [brs_pkg::M_TUSER_W-1:0]       o_m_tuser,
    // config write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [brs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [brs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import brs_pkg::*;

    t_cfg cfg;

    brs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // schedule state
    logic [BLK_W-1:0]  r_range_start, n_range_start;
    logic [RB_W-1:0]   r_range_count, n_range_count;
    logic [RB_W-1:0]   r_index, n_index;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [BLK_W-1:0]  r_blocks_before, n_blocks_before;
    t_phase            r_phase, n_phase;

    // output register
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;

    logic accept;
    logic restart;

    // state as seen by this beat (restart folded in)
    logic [BLK_W-1:0]  e_range_start;
    logic [RB_W-1:0]   e_range_count;
    logic [RB_W-1:0]   e_index;
    logic [PASS_W-1:0] e_pass;
    logic [BLK_W-1:0]  e_blocks_before;
    t_phase            e_phase;

    // range load
    logic [TOTAL_W-1:0] avail;
    logic [RB_W-1:0]    cnt_file;
    logic [BLK_W-1:0]   left;
    logic [RB_W-1:0]    loaded;
    logic               do_load;
    logic [RB_W-1:0]    cur_count;

    // descriptor math
    logic [BLK_W:0]          blk;
    logic [FL_W+BLOCK_SHIFT:0] off_full;
    logic [FL_W-1:0]         off;
    logic [FL_W-1:0]         rem;
    logic [LEN_W-1:0]        len;
    logic [RB_W-1:0]         idx_inc;
    logic [BLK_W:0]          next_start;

    // descriptor fields
    logic [BLK_W-1:0]  d_block;
    logic [FL_W-1:0]   d_offset;
    logic [LEN_W-1:0]  d_len;
    logic [PASS_W-1:0] d_pass;
    logic              d_end;
    logic              d_fin;

    assign o_s_tready = !r_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign restart    = i_s_tdata[0];

    assign e_range_start   = restart ? cfg.first_block : r_range_start;
    assign e_range_count   = restart ? '0 : r_range_count;
    assign e_index         = restart ? '0 : r_index;
    assign e_pass          = restart ? '0 : r_pass;
    assign e_blocks_before = restart ? '0 : r_blocks_before;
    assign e_phase         = restart ? PH_SENDING : r_phase;

    // range length = min(range_blocks, blocks left in file, blocks left under limit)
    assign avail = (cfg.total_blocks > {1'b0, e_range_start})
                 ? cfg.total_blocks - {1'b0, e_range_start} : '0;
    assign cnt_file = (avail < {{(TOTAL_W-RB_W){1'b0}}, cfg.range_blocks})
                    ? avail[RB_W-1:0] : cfg.range_blocks;
    assign left = (cfg.block_limit > e_blocks_before)
                ? cfg.block_limit - e_blocks_before : '0;
    assign loaded = ((cfg.block_limit != '0) && (left < {{(BLK_W-RB_W){1'b0}}, cnt_file}))
                  ? left[RB_W-1:0] : cnt_file;

    assign do_load   = (e_index == '0) && (e_pass == '0);
    assign cur_count = do_load ? loaded : e_range_count;

    assign blk      = {1'b0, e_range_start} + {{(BLK_W+1-RB_W){1'b0}}, e_index};
    assign off_full = {{(FL_W-BLK_W){1'b0}}, blk, {BLOCK_SHIFT{1'b0}}};
    assign off      = off_full[FL_W-1:0];
    assign rem      = (cfg.file_length > off) ? cfg.file_length - off : '0;
    assign len      = (rem < FL_W'(BLOCK_BYTES)) ? rem[LEN_W-1:0] : LEN_W'(BLOCK_BYTES);

    assign idx_inc    = e_index + 1'b1;
    assign next_start = {1'b0, e_range_start} + {{(BLK_W+1-RB_W){1'b0}}, cur_count};

    always_comb begin
        n_range_start   = e_range_start;
        n_range_count   = e_range_count;
        n_index         = e_index;
        n_pass          = e_pass;
        n_blocks_before = e_blocks_before;
        n_phase         = e_phase;
        d_block         = '0;
        d_offset        = '0;
        d_len           = '0;
        d_pass          = '0;
        d_end           = 1'b0;
        d_fin           = 1'b0;

        unique case (e_phase)
            PH_DONE: begin
                d_fin = 1'b1;
            end
            PH_END: begin
                // id space ran out: marker id wrapped to 0
                n_phase = PH_DONE;
                d_end   = 1'b1;
            end
            PH_SENDING: begin
                if (do_load && (loaded == '0)) begin
                    // nothing left: marker carries the next block id
                    n_range_count = '0;
                    n_phase       = PH_DONE;
                    d_block       = e_range_start;
                    d_end         = 1'b1;
                end else begin
                    n_range_count = cur_count;
                    d_block       = blk[BLK_W-1:0];
                    d_offset      = off;
                    d_len         = len;
                    d_pass        = e_pass;
                    if (idx_inc >= cur_count) begin
                        n_index = '0;
                        if (e_pass >= cfg.extra_passes) begin
                            // range done, move on
                            n_pass          = '0;
                            n_blocks_before = e_blocks_before
                                            + {{(BLK_W-RB_W){1'b0}}, cur_count};
                            n_range_count   = '0;
                            if (next_start[BLK_W]) begin
                                n_range_start = '0;
                                n_phase       = PH_END;
                            end else begin
                                n_range_start = next_start[BLK_W-1:0];
                            end
                        end else begin
                            n_pass = e_pass + 1'b1;
                        end
                    end else begin
                        n_index = idx_inc;
                    end
                end
            end
            default: begin
                d_fin = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start   <= '0;
            r_range_count   <= '0;
            r_index         <= '0;
            r_pass          <= '0;
            r_blocks_before <= '0;
            r_phase         <= PH_SENDING;
        end else if (accept) begin
            r_range_start   <= n_range_start;
            r_range_count   <= n_range_count;
            r_index         <= n_index;
            r_pass          <= n_pass;
            r_blocks_before <= n_blocks_before;
            r_phase         <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (accept) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_tdata <= {{(M_TDATA_W-BLK_W-FL_W-LEN_W-PASS_W){1'b0}},
                          d_pass, d_len, d_offset, d_block};
            r_m_tuser <= {d_fin, d_end};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule
`default_nettype wire

/* design/brs_cfg.sv */
`default_nettype none
module brs_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [brs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [brs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output brs_pkg::t_cfg                       o_cfg
);
    import brs_pkg::*;

    t_cfg               r_cfg;
    logic               cfg_we;
    logic [TOTAL_W-1:0] total_blocks;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // block count rounded up, kept with the length so the step logic stays short
    assign total_blocks = {1'b0, i_cfg_data[FL_W-1:BLOCK_SHIFT]}
                        + {{(TOTAL_W-1){1'b0}}, |i_cfg_data[BLOCK_SHIFT-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_blocks <= RANGE_BLOCKS_RST;
            r_cfg.extra_passes <= '0;
            r_cfg.block_limit  <= '0;
            r_cfg.first_block  <= '0;
            r_cfg.file_length  <= '0;
            r_cfg.total_blocks <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_RANGE_BLOCKS: r_cfg.range_blocks <= i_cfg_data[RB_W-1:0];
                CFG_EXTRA_PASSES: r_cfg.extra_passes <= i_cfg_data[PASS_W-1:0];
                CFG_BLOCK_LIMIT:  r_cfg.block_limit  <= i_cfg_data[BLK_W-1:0];
                CFG_FIRST_BLOCK:  r_cfg.first_block  <= i_cfg_data[BLK_W-1:0];
                CFG_FILE_LENGTH: begin
                    r_cfg.file_length  <= i_cfg_data[FL_W-1:0];
                    r_cfg.total_blocks <= total_blocks;
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire
